### design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define CBC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// clocked assertion, checked in reset too
`define CBC_ASSERT_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### design/cbc_pkg.sv
// shared types, constants and helpers of the color blob centroid block
package cbc_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int PIX_W     = 8;
    localparam int THR_W     = 21;
    localparam int SIZE_W    = 11;
    localparam int CNT_OUT_W = 21;
    localparam int CEN_W     = 11;
    localparam int SZ_CMP_W  = 13;

    localparam int S_TDATA_W = 3 * PIX_W;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 1;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    localparam logic [PIX_W-1:0]  RST_RED_MAX      = 8'd100;
    localparam logic [PIX_W-1:0]  RST_GREEN_MIN    = 8'd150;
    localparam logic [PIX_W-1:0]  RST_BLUE_MAX     = 8'd100;
    localparam logic [THR_W-1:0]  RST_THRESHOLD    = 21'd10;
    localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH  = 11'd52;
    localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT = 11'd39;

    typedef enum logic [2:0] {
        REG_RED_MAX      = 3'd0,
        REG_GREEN_MIN    = 3'd1,
        REG_BLUE_MAX     = 3'd2,
        REG_THRESHOLD    = 3'd3,
        REG_FRAME_WIDTH  = 3'd4,
        REG_FRAME_HEIGHT = 3'd5
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_EVAL,
        ST_DIV_X,
        ST_DIV_Y
    } t_state;

    // zero reads as one, above the limit saturates
    function automatic logic [SZ_CMP_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                       input logic [SZ_CMP_W-1:0] maxv);
        logic [SZ_CMP_W-1:0] ext;
        ext = SZ_CMP_W'(v);
        if (v == '0) begin
            return SZ_CMP_W'(1);
        end else if (ext > maxv) begin
            return maxv;
        end
        return ext;
    endfunction

endpackage

### design/color_blob_centroid.sv
// top level: color threshold, marked pixel accumulation and centroid division
// pixels are taken back to back; after the last pixel of a frame, input stalls through
// the eval state and, when there is a mean, through the shared divider running one
// quotient bit a cycle, x then y
// the result waits in the output register, and the next frame end waits until it is taken
// synchronous active low reset loads register defaults and clears position and sums
module color_blob_centroid
    import cbc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // red, green, blue
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // marked_count, center_x, center_y, pad
    output logic [M_TUSER_W-1:0] m_axis_tuser,   // visible
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int QW   = (CW > RW) ? CW : RW;
    localparam int CNTW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int SW   = QW + CNTW;
    localparam int CMPW = (CNTW > THR_W) ? CNTW : THR_W;

    logic [PIX_W-1:0]  r_red_max;
    logic [PIX_W-1:0]  r_green_min;
    logic [PIX_W-1:0]  r_blue_max;
    logic [THR_W-1:0]  r_threshold;
    logic [SIZE_W-1:0] r_frame_width;
    logic [SIZE_W-1:0] r_frame_height;

    t_state            r_state;
    t_state            n_state;

    logic [CW-1:0]     r_col;
    logic [RW-1:0]     r_row;
    logic [CNTW-1:0]   r_count;
    logic [SW-1:0]     r_sum_x;
    logic [SW-1:0]     r_sum_y;

    logic              r_out_valid;
    logic              r_vis;
    logic [CNT_OUT_W-1:0] r_cnt_out;
    logic [CEN_W-1:0]  r_cx;
    logic [CEN_W-1:0]  r_cy;

    logic [PIX_W-1:0]  red;
    logic [PIX_W-1:0]  green;
    logic [PIX_W-1:0]  blue;
    logic [PIX_W+1:0]  green2;
    logic [PIX_W+1:0]  red3;
    logic [PIX_W+1:0]  blue3;
    logic              marked;
    logic [SZ_CMP_W-1:0] w_clamp;
    logic [SZ_CMP_W-1:0] h_clamp;
    logic [SZ_CMP_W-1:0] col_p1;
    logic [SZ_CMP_W-1:0] row_p1;
    logic              row_end;
    logic              frame_end;
    logic              vis;
    logic              has_mean;
    logic              pix_take;
    logic              out_load;
    logic              cfg_wr;
    t_reg_idx          reg_idx;

    logic              div_start;
    logic [SW-1:0]     div_dividend;
    logic              div_done;
    logic [QW-1:0]     div_q;

    // pixel classification and position
    always_comb begin
        red       = s_axis_tdata[PIX_W-1:0];
        green     = s_axis_tdata[2*PIX_W-1:PIX_W];
        blue      = s_axis_tdata[3*PIX_W-1:2*PIX_W];
        green2    = {1'b0, green, 1'b0};
        red3      = {2'b00, red} + {1'b0, red, 1'b0};
        blue3     = {2'b00, blue} + {1'b0, blue, 1'b0};
        marked    = (red < r_red_max) && (green > r_green_min) && (blue < r_blue_max)
                    && (green2 > red3) && (green2 > blue3);
        w_clamp   = clamp_size(r_frame_width, SZ_CMP_W'(MAX_WIDTH));
        h_clamp   = clamp_size(r_frame_height, SZ_CMP_W'(MAX_HEIGHT));
        col_p1    = SZ_CMP_W'(r_col) + SZ_CMP_W'(1);
        row_p1    = SZ_CMP_W'(r_row) + SZ_CMP_W'(1);
        row_end   = (col_p1 >= w_clamp);
        frame_end = row_end && (row_p1 >= h_clamp);
        vis       = (CMPW'(r_count) >= CMPW'(r_threshold));
        has_mean  = vis && (r_count != '0);
        pix_take  = s_axis_tvalid && s_axis_tready;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        div_dividend  = r_sum_x;
        out_load      = 1'b0;
        case (r_state)
            ST_RUN: begin
                // a frame end waits until the previous result is taken
                s_axis_tready = !(frame_end && r_out_valid);
                if (s_axis_tvalid && frame_end && !r_out_valid) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (has_mean) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV_X;
                end else begin
                    out_load = 1'b1;
                    n_state  = ST_RUN;
                end
            end
            ST_DIV_X: begin
                if (div_done) begin
                    div_start    = 1'b1;
                    div_dividend = r_sum_y;
                    n_state      = ST_DIV_Y;
                end
            end
            ST_DIV_Y: begin
                if (div_done) begin
                    out_load = 1'b1;
                    n_state  = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    // position and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_count <= '0;
            r_sum_x <= '0;
            r_sum_y <= '0;
        end else if (pix_take) begin
            if (marked) begin
                r_count <= r_count + CNTW'(1);
                r_sum_x <= r_sum_x + SW'(r_col);
                r_sum_y <= r_sum_y + SW'(r_row);
            end
            if (frame_end) begin
                r_col <= '0;
                r_row <= '0;
            end else if (row_end) begin
                r_col <= '0;
                r_row <= r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end else if ((r_state == ST_EVAL && !has_mean) || (r_state == ST_DIV_Y && div_done)) begin
            r_count <= '0;
            r_sum_x <= '0;
            r_sum_y <= '0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EVAL) begin
            r_vis     <= vis;
            r_cnt_out <= CNT_OUT_W'(r_count);
            if (!has_mean) begin
                r_cx <= '1;
                r_cy <= '1;
            end
        end
        if (r_state == ST_DIV_X && div_done) begin
            r_cx <= CEN_W'(div_q);
        end
        if (r_state == ST_DIV_Y && div_done) begin
            r_cy <= CEN_W'(div_q);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'({r_cy, r_cx, r_cnt_out});
    assign m_axis_tuser  = r_vis;

    cbc_div #(
        .QW   (QW),
        .CNTW (CNTW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // configuration registers
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_max      <= RST_RED_MAX;
            r_green_min    <= RST_GREEN_MIN;
            r_blue_max     <= RST_BLUE_MAX;
            r_threshold    <= RST_THRESHOLD;
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_RED_MAX:      r_red_max      <= pwdata[PIX_W-1:0];
                REG_GREEN_MIN:    r_green_min    <= pwdata[PIX_W-1:0];
                REG_BLUE_MAX:     r_blue_max     <= pwdata[PIX_W-1:0];
                REG_THRESHOLD:    r_threshold    <= pwdata[THR_W-1:0];
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[SIZE_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_RED_MAX:      prdata = APB_DW'(r_red_max);
            REG_GREEN_MIN:    prdata = APB_DW'(r_green_min);
            REG_BLUE_MAX:     prdata = APB_DW'(r_blue_max);
            REG_THRESHOLD:    prdata = APB_DW'(r_threshold);
            REG_FRAME_WIDTH:  prdata = APB_DW'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DW'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

endmodule

### design/cbc_div.sv
// restoring divider, one quotient bit per cycle, shared for both centroid axes
module cbc_div #(
    parameter int QW   = 10,
    parameter int CNTW = 21
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [QW+CNTW-1:0] i_dividend,
    input  logic [CNTW-1:0]   i_divisor,
    output logic              o_done,
    output logic [QW-1:0]     o_quotient
);

    localparam int SCW = $clog2(QW + 1);

    logic              r_busy;
    logic              r_done;
    logic [SCW-1:0]    r_step;
    logic [CNTW-1:0]   r_rem;
    logic [QW-1:0]     r_quo;
    logic [CNTW-1:0]   r_div;

    logic [CNTW:0]     trial;
    logic [CNTW:0]     diff;
    logic              q_bit;
    logic [QW:0]       quo_shift;
    logic [CNTW-1:0]   n_rem;
    logic [QW-1:0]     n_quo;

    always_comb begin
        trial     = {r_rem, r_quo[QW-1]};
        diff      = trial - {1'b0, r_div};
        q_bit     = (trial >= {1'b0, r_div});
        n_rem     = q_bit ? diff[CNTW-1:0] : trial[CNTW-1:0];
        quo_shift = {r_quo, q_bit};
        n_quo     = quo_shift[QW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= SCW'(QW);
        end else if (r_busy) begin
            r_step <= r_step - SCW'(1);
            if (r_step == SCW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[QW+CNTW-1:QW];
            r_quo <= i_dividend[QW-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### design/cbc_checker.sv
// port level checks of the color blob centroid block and their binding
`include "assert_macros.svh"

module cbc_checker
    import cbc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [M_TDATA_W-1:0] m_axis_tdata,   // marked_count, center_x, center_y, pad
    input  logic [M_TUSER_W-1:0] m_axis_tuser,   // visible
    input  logic                 pready
);

    // no result right after a reset cycle
    `CBC_ASSERT_NR(a_quiet_after_reset, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

    `CBC_ASSERT(a_result_holds, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // a hidden target reports both centers as minus one
    `CBC_ASSERT(a_hidden_center, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[42:21] == 22'h3FFFFF, "hidden target with a center")

    `CBC_ASSERT_NR(a_pready_high, pready, "config port not ready")

endmodule

bind color_blob_centroid cbc_checker u_cbc_checker (.*);

### bench/color_blob_centroid_test.sv
// testbench for color_blob_centroid: directed table plus randomized frames checked by a predictor
module color_blob_centroid_test;
    import cbc_pkg::*;

    localparam int SETTLE      = 40;
    localparam int CYCLE_LIMIT = 500000;
    localparam logic [CEN_W-1:0] NO_CENTER = '1;

    typedef struct packed {
        logic                 visible;
        logic [CNT_OUT_W-1:0] count;
        logic [CEN_W-1:0]     cx;
        logic [CEN_W-1:0]     cy;
    } t_blob_report;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_PIXEL,
        ROW_PIXEL_TYPED
    } t_row_kind;

    typedef struct {
        t_row_kind    kind;
        t_reg_idx     idx;
        logic [31:0]  value;
        t_blob_report want;
    } t_step_row;

    localparam t_blob_report HIT_AT_ORIGIN = '{1'b1, 21'd1, 11'd0, 11'd0};
    localparam t_blob_report NOT_MARKED    = '{1'b0, 21'd0, NO_CENTER, NO_CENTER};
    localparam t_blob_report EMPTY_SEEN    = '{1'b1, 21'd0, NO_CENTER, NO_CENTER};
    localparam t_blob_report BELOW_LIMIT   = '{1'b0, 21'd1, NO_CENTER, NO_CENTER};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // red, green, blue
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;        // marked_count, center_x, center_y, pad
    logic [M_TUSER_W-1:0] m_axis_tuser;        // visible
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [APB_AW-1:0]    paddr = '0;
    logic [APB_DW-1:0]    pwdata = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // predictor copy of the registers and the frame position and sums
    logic [PIX_W-1:0]  lim_red     = RST_RED_MAX;
    logic [PIX_W-1:0]  floor_green = RST_GREEN_MIN;
    logic [PIX_W-1:0]  lim_blue    = RST_BLUE_MAX;
    logic [THR_W-1:0]  visible_min = RST_THRESHOLD;
    logic [SIZE_W-1:0] span_w      = RST_FRAME_WIDTH;
    logic [SIZE_W-1:0] span_h      = RST_FRAME_HEIGHT;
    int unsigned       col_pos = 0;
    int unsigned       row_pos = 0;
    longint unsigned   marked_n = 0;
    longint unsigned   x_sum = 0;
    longint unsigned   y_sum = 0;

    t_blob_report expected_reports[$];
    int           mismatches = 0;
    int           reports_checked = 0;
    int           visible_seen = 0;
    int           pixels_sent = 0;
    int           cycle_count = 0;
    int           sender_idle_pct = 0;
    int           recv_stall_pct = 0;

    color_blob_centroid dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timed out after %0d cycles, %0d reports outstanding",
                     cycle_count, expected_reports.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [31:0] pixel_word(input logic [7:0] r, g, b);
        return {8'h00, b, g, r};
    endfunction

    function automatic int unsigned usable_span(input logic [SIZE_W-1:0] v, input int unsigned cap);
        if (v == '0) begin
            return 1;
        end else if (v > cap) begin
            return cap;
        end
        return v;
    endfunction

    task automatic log_mismatch(input string what, input t_blob_report want,
                                input t_blob_report got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s: expected vis=%0d cnt=%0d x=%0d y=%0d, got vis=%0d cnt=%0d x=%0d y=%0d",
                     what, want.visible, want.count, $signed(want.cx), $signed(want.cy),
                     got.visible, got.count, $signed(got.cx), $signed(got.cy));
        end
    endtask

    always @(posedge i_clk) begin : check_reports
        t_blob_report got;
        t_blob_report want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.visible = m_axis_tuser[0];
            got.count   = m_axis_tdata[20:0];
            got.cx      = m_axis_tdata[31:21];
            got.cy      = m_axis_tdata[42:32];
            reports_checked++;
            if (got.visible) begin
                visible_seen++;
            end
            if (expected_reports.size() == 0) begin
                log_mismatch("report with none pending", '0, got);
            end else begin
                want = expected_reports.pop_front();
                if (got.visible !== want.visible || got.count !== want.count ||
                    got.cx !== want.cx || got.cy !== want.cy) begin
                    log_mismatch("report mismatch", want, got);
                end
            end
        end
    end

    // threshold test, accumulation, and the frame report on the last pixel
    task automatic predict_pixel(input logic [23:0] px, output bit done_frame,
                                 output t_blob_report rep);
        int unsigned r, g, b, w, h;
        bit hit, row_end;
        r = px[7:0];
        g = px[15:8];
        b = px[23:16];
        w = usable_span(span_w, DEF_MAX_WIDTH);
        h = usable_span(span_h, DEF_MAX_HEIGHT);
        hit = r < lim_red && g > floor_green && b < lim_blue && 2 * g > 3 * r && 2 * g > 3 * b;
        if (hit) begin
            marked_n++;
            x_sum += col_pos;
            y_sum += row_pos;
        end
        row_end = col_pos + 1 >= w;
        done_frame = row_end && (row_pos + 1 >= h);
        rep = '0;
        if (!done_frame) begin
            if (row_end) begin
                col_pos = 0;
                row_pos++;
            end else begin
                col_pos++;
            end
        end else begin
            rep.visible = marked_n >= visible_min;
            rep.count   = marked_n[20:0];
            rep.cx      = NO_CENTER;
            rep.cy      = NO_CENTER;
            if (rep.visible && marked_n != 0) begin
                rep.cx = CEN_W'(x_sum / marked_n);
                rep.cy = CEN_W'(y_sum / marked_n);
            end
            col_pos  = 0;
            row_pos  = 0;
            marked_n = 0;
            x_sum    = 0;
            y_sum    = 0;
        end
    endtask

    task automatic push_pixel(input logic [23:0] px, input bit typed,
                              input t_blob_report typed_rep);
        bit done_frame;
        t_blob_report rep;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_pixel(px, done_frame, rep);
        if (done_frame) begin
            expected_reports.push_back(typed ? typed_rep : rep);
        end
        pixels_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain(input int settle);
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (expected_reports.size() != 0);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic reg_write(input t_reg_idx idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_RED_MAX:      lim_red     = val[PIX_W-1:0];
            REG_GREEN_MIN:    floor_green = val[PIX_W-1:0];
            REG_BLUE_MAX:     lim_blue    = val[PIX_W-1:0];
            REG_THRESHOLD:    visible_min = val[THR_W-1:0];
            REG_FRAME_WIDTH:  span_w      = val[SIZE_W-1:0];
            REG_FRAME_HEIGHT: span_h      = val[SIZE_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic write_settings(input logic [7:0] r, g, b, input logic [THR_W-1:0] thr,
                                  input logic [SIZE_W-1:0] w, h);
        drain(SETTLE);
        reg_write(REG_RED_MAX, 32'(r));
        reg_write(REG_GREEN_MIN, 32'(g));
        reg_write(REG_BLUE_MAX, 32'(b));
        reg_write(REG_THRESHOLD, 32'(thr));
        reg_write(REG_FRAME_WIDTH, 32'(w));
        reg_write(REG_FRAME_HEIGHT, 32'(h));
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin
                sender_idle_pct = 0;
                recv_stall_pct  = 0;
            end
            1: begin
                sender_idle_pct = 65;
                recv_stall_pct  = 0;
            end
            2: begin
                sender_idle_pct = 0;
                recv_stall_pct  = 65;
            end
            default: begin
                sender_idle_pct = 22;
                recv_stall_pct  = 22;
            end
        endcase
    endtask

    initial begin : stimulus
        t_step_row        directed_rows [35];
        int               phase;
        int               n_items;
        bit               big;
        int unsigned      gv, rl, bl;
        logic [23:0]      px;
        logic [7:0]       cr, cg, cb;
        logic [THR_W-1:0] thr;

        directed_rows = '{
            '{ROW_WRITE, REG_FRAME_WIDTH, 32'd1, '0},
            '{ROW_WRITE, REG_FRAME_HEIGHT, 32'd1, '0},
            '{ROW_WRITE, REG_THRESHOLD, 32'd1, '0},
            // reset color limits, each bound one step inside and on the edge
            '{ROW_PIXEL_TYPED, REG_RED_MAX, pixel_word(8'd99, 8'd151, 8'd99), HIT_AT_ORIGIN},
            '{ROW_PIXEL_TYPED, REG_RED_MAX, pixel_word(8'd100, 8'd151, 8'd99), NOT_MARKED},
            '{ROW_PIXEL_TYPED, REG_RED_MAX, pixel_word(8'd99, 8'd150, 8'd99), NOT_MARKED},
            '{ROW_PIXEL_TYPED, REG_RED_MAX, pixel_word(8'd99, 8'd151, 8'd100), NOT_MARKED},
            '{ROW_PIXEL_TYPED, REG_RED_MAX, pixel_word(8'd0, 8'd255, 8'd0), HIT_AT_ORIGIN},
            '{ROW_PIXEL_TYPED, REG_RED_MAX, pixel_word(8'd255, 8'd255, 8'd255), NOT_MARKED},
            '{ROW_PIXEL_TYPED, REG_RED_MAX, pixel_word(8'd0, 8'd0, 8'd0), NOT_MARKED},
            '{ROW_WRITE, REG_RED_MAX, 32'd255, '0},
            '{ROW_WRITE, REG_GREEN_MIN, 32'd0, '0},
            '{ROW_WRITE, REG_BLUE_MAX, 32'd255, '0},
            // green over one and a half times red and blue
            '{ROW_PIXEL_TYPED, REG_RED_MAX, pixel_word(8'd66, 8'd100, 8'd0), HIT_AT_ORIGIN},
            '{ROW_PIXEL_TYPED, REG_RED_MAX, pixel_word(8'd67, 8'd100, 8'd0), NOT_MARKED},
            '{ROW_PIXEL_TYPED, REG_RED_MAX, pixel_word(8'd0, 8'd100, 8'd66), HIT_AT_ORIGIN},
            '{ROW_PIXEL_TYPED, REG_RED_MAX, pixel_word(8'd0, 8'd100, 8'd67), NOT_MARKED},
            '{ROW_PIXEL_TYPED, REG_RED_MAX, pixel_word(8'd0, 8'd1, 8'd0), HIT_AT_ORIGIN},
            '{ROW_PIXEL_TYPED, REG_RED_MAX, pixel_word(8'd0, 8'd0, 8'd0), NOT_MARKED},
            // zero threshold with nothing marked, then the largest threshold with one marked pixel
            '{ROW_WRITE, REG_THRESHOLD, 32'd0, '0},
            '{ROW_PIXEL_TYPED, REG_RED_MAX, pixel_word(8'd255, 8'd255, 8'd255), EMPTY_SEEN},
            '{ROW_WRITE, REG_THRESHOLD, 32'h1F_FFFF, '0},
            '{ROW_PIXEL_TYPED, REG_RED_MAX, pixel_word(8'd0, 8'd255, 8'd0), BELOW_LIMIT},
            '{ROW_WRITE, REG_THRESHOLD, 32'd1, '0},
            // zero sizes act as one, then a three by two frame
            '{ROW_WRITE, REG_FRAME_WIDTH, 32'd0, '0},
            '{ROW_WRITE, REG_FRAME_HEIGHT, 32'd0, '0},
            '{ROW_PIXEL_TYPED, REG_RED_MAX, pixel_word(8'd10, 8'd200, 8'd10), HIT_AT_ORIGIN},
            '{ROW_WRITE, REG_FRAME_WIDTH, 32'd3, '0},
            '{ROW_WRITE, REG_FRAME_HEIGHT, 32'd2, '0},
            '{ROW_PIXEL, REG_RED_MAX, pixel_word(8'd0, 8'd200, 8'd0), '0},
            '{ROW_PIXEL, REG_RED_MAX, pixel_word(8'd255, 8'd0, 8'd0), '0},
            '{ROW_PIXEL, REG_RED_MAX, pixel_word(8'd0, 8'd200, 8'd0), '0},
            '{ROW_PIXEL, REG_RED_MAX, pixel_word(8'd0, 8'd200, 8'd0), '0},
            '{ROW_PIXEL, REG_RED_MAX, pixel_word(8'd0, 8'd0, 8'd255), '0},
            '{ROW_PIXEL, REG_RED_MAX, pixel_word(8'd0, 8'd200, 8'd0), '0}
        };

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        set_idling(0);
        foreach (directed_rows[i]) begin
            case (directed_rows[i].kind)
                ROW_WRITE: begin
                    drain(SETTLE);
                    reg_write(directed_rows[i].idx, directed_rows[i].value);
                end
                ROW_PIXEL: begin
                    push_pixel(directed_rows[i].value[23:0], 1'b0, '0);
                end
                default: begin
                    push_pixel(directed_rows[i].value[23:0], 1'b1, directed_rows[i].want);
                end
            endcase
        end

        phase = 0;
        while (pixels_sent < 1850) begin
            set_idling(phase % 4);
            big = (phase == 2);
            if (big) begin
                // one full row past the width limit
                write_settings(8'hFF, 8'h00, 8'hFF, 21'd5, 11'h7FF, 11'd1);
                n_items = 1030;
            end else begin
                case ($urandom_range(3))
                    0: begin
                        cr = RST_RED_MAX;
                        cg = RST_GREEN_MIN;
                        cb = RST_BLUE_MAX;
                    end
                    1: begin
                        cr = 8'($urandom);
                        cg = 8'($urandom);
                        cb = 8'($urandom);
                    end
                    2: begin
                        cr = 8'hFF;
                        cg = 8'h00;
                        cb = 8'hFF;
                    end
                    default: begin
                        cr = 8'h00;
                        cg = 8'hFF;
                        cb = 8'h00;
                    end
                endcase
                case ($urandom_range(3))
                    0: thr = '0;
                    3: thr = THR_W'($urandom);
                    default: thr = THR_W'($urandom_range(12, 1));
                endcase
                write_settings(cr, cg, cb, thr, SIZE_W'($urandom_range(8, 1)),
                               SIZE_W'($urandom_range(6, 1)));
                n_items = $urandom_range(260, 120);
            end
            repeat (n_items) begin
                if ($urandom_range(99) < 60) begin
                    gv = $urandom_range(255, floor_green);
                    rl = (2 * gv) / 3;
                    bl = rl;
                    if (lim_red < rl) begin
                        rl = lim_red;
                    end
                    if (lim_blue < bl) begin
                        bl = lim_blue;
                    end
                    px = {8'($urandom_range(bl, 0)), 8'(gv), 8'($urandom_range(rl, 0))};
                end else begin
                    px = 24'($urandom);
                end
                push_pixel(px, 1'b0, '0);
                if ($urandom_range(49) == 0) begin
                    drain(0);
                end
            end
            phase++;
        end

        drain(SETTLE);
        $display("%0d pixels over %0d register settings, %0d frame reports checked (%0d visible)",
                 pixels_sent, phase, reports_checked, visible_seen);
        $display("frames from one pixel up to a full saturated row, idle and stall mixes");
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
